/* rtl/trapezoid_step_pulse_profile_defines.svh */
// assertion macros for the trapezoid step pulse profile block
// used by modules that check their own control logic; needs clk and rst_n in scope
`ifndef TRAPEZOID_STEP_PULSE_PROFILE_DEFINES_SVH
`define TRAPEZOID_STEP_PULSE_PROFILE_DEFINES_SVH

// property sampled on clk, ignored while reset is asserted
`define TSPP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true outside reset
`define TSPP_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/tspp_pkg.sv */
// shared types, codes and constants of the trapezoid step pulse profile block
// no dependencies
`timescale 1ns / 1ps

package tspp_pkg;

    // default values for the top level parameters
    localparam int FRAC_BITS_DEF       = 16;
    localparam int STEP_COUNT_BITS_DEF = 24;

    // fixed field widths
    localparam int SPEED_W   = 32;
    localparam int TOTAL_W   = 24;
    localparam int US_W      = 16;
    localparam int STEPNUM_W = 24;
    localparam int PHASE_W   = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [31:0] SAT32     = 32'hFFFF_FFFF;
    localparam logic [15:0] US_MAX    = 16'hFFFF;
    localparam logic [31:0] US_PER_MS = 32'd1000;

    // register reset values
    localparam logic [31:0] MAX_SPEED_RST   = 32'd235930;
    localparam logic [31:0] MIN_SPEED_RST   = 32'd65536;
    localparam logic [31:0] ACCEL_TIME_RST  = 32'd6553600;
    localparam logic [31:0] STEP_ANGLE_RST  = 32'd117965;
    localparam logic [23:0] TOTAL_STEPS_RST = 24'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_SPEED   = 3'd0,
        CFG_MIN_SPEED   = 3'd1,
        CFG_ACCEL_TIME  = 3'd2,
        CFG_STEP_ANGLE  = 3'd3,
        CFG_TOTAL_STEPS = 3'd4
    } cfg_idx_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        DIV_RATE = 2'd0,
        DIV_PMIN = 2'd1,
        DIV_PCUR = 2'd2
    } div_sel_t;

    typedef enum logic {
        MUL_RAMP = 1'b0,
        MUL_US   = 1'b1
    } mul_sel_t;

    // commands from controller to datapath
    typedef struct packed {
        logic     begin_load;
        logic     div_start;
        div_sel_t div_sel;
        logic     step_adv;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     speed_upd;
        logic     cruise_upd;
        logic     stop;
        logic     out_load;
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic moving;
        logic at_end;
        logic rate_pos;
        logic ramping;
        logic div_done;
        logic out_full;
    } dp_status_t;

endpackage

/* rtl/tspp_if.sv */
// channel interfaces: step request, step result and configuration write
// depends on tspp_pkg for field widths
`timescale 1ns / 1ps

interface tspp_req_if;
    logic valid;
    logic ready;
    logic begin_req;
    modport source (output valid, output begin_req, input ready);
    modport sink (input valid, input begin_req, output ready);
endinterface

interface tspp_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [tspp_pkg::US_W-1:0]      pulse_width_us;
    logic [tspp_pkg::STEPNUM_W-1:0] step_number;
    logic [tspp_pkg::PHASE_W-1:0]   phase;
    logic                           last;
    modport source (output valid, output pulse_width_us, output step_number,
                    output phase, output last, input ready);
    modport sink (input valid, input pulse_width_us, input step_number,
                  input phase, input last, output ready);
endinterface

interface tspp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tspp_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                    data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/trapezoid_step_pulse_profile.sv */
// trapezoid step pulse profile: one step request in, at most one pulse period beat out
// a ramp step runs the ramp multiply, the speed update, a serial divider pass and the microsecond multiply;
// a cruise step runs only the microsecond multiply; a begin request first runs one or two divider passes
// throughput: one request at a time, next request taken the cycle after the result loads
// reset: rst_n asynchronous active low, registers to defaults, no move running
`timescale 1ns / 1ps

module trapezoid_step_pulse_profile #(
    parameter int FRAC_BITS       = tspp_pkg::FRAC_BITS_DEF,
    parameter int STEP_COUNT_BITS = tspp_pkg::STEP_COUNT_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    tspp_req_if.sink  step_req,
    tspp_rsp_if.source step_rsp,
    tspp_cfg_if.sink  cfg
);

    tspp_pkg::ctrl_cmd_t  cmd;
    tspp_pkg::dp_status_t status;
    logic                 req_ready;

    // sequencer
    tspp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (step_req.valid),
        .in_ready  (req_ready),
        .begin_req (step_req.begin_req),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic and state
    tspp_datapath #(
        .FRAC_BITS       (FRAC_BITS),
        .STEP_COUNT_BITS (STEP_COUNT_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .out_ready      (step_rsp.ready),
        .out_valid      (step_rsp.valid),
        .pulse_width_us (step_rsp.pulse_width_us),
        .step_number    (step_rsp.step_number),
        .phase          (step_rsp.phase),
        .last           (step_rsp.last)
    );

    assign step_req.ready = req_ready;
    assign cfg.ready      = 1'b1;

endmodule

/* rtl/tspp_div.sv */
// restoring serial divider: (num << FRAC_BITS) / den, one quotient bit per cycle
// saturates at all ones; depends on tspp_pkg
`timescale 1ns / 1ps

module tspp_div #(
    parameter int FRAC_BITS = tspp_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        busy,
    output logic        done,
    output logic [31:0] quo
);

    localparam int QW  = 32 + FRAC_BITS;
    localparam int CNW = $clog2(QW + 1);

    logic [QW-1:0]  work_reg, work_next;
    logic [31:0]    rem_reg, rem_next;
    logic [31:0]    den_reg;
    logic [CNW-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [32:0]    trial;
    logic           fits;

    // one restoring step
    always_comb
    begin
        trial     = {rem_reg, work_reg[QW-1]};
        fits      = trial >= {1'b0, den_reg};
        rem_next  = fits ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
        work_next = {work_reg[QW-2:0], fits};
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNW'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNW'(1);
                if (cnt_reg == CNW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend / quotient shift register and remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= {num, {FRAC_BITS{1'b0}}};
            rem_reg  <= '0;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    // a zero divisor gives all ones and so saturates too
    assign quo  = (|work_reg[QW-1:32]) ? tspp_pkg::SAT32 : work_reg[31:0];
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

/* rtl/tspp_datapath.sv */
// datapath: configuration registers, move state, multiplier, divider, result register
// depends on tspp_pkg, tspp_div and the assertion macro header
`timescale 1ns / 1ps
`include "trapezoid_step_pulse_profile_defines.svh"

module tspp_datapath #(
    parameter int FRAC_BITS       = tspp_pkg::FRAC_BITS_DEF,
    parameter int STEP_COUNT_BITS = tspp_pkg::STEP_COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tspp_pkg::ctrl_cmd_t            cmd,
    output tspp_pkg::dp_status_t           status,
    input  logic                           cfg_valid,
    input  logic [tspp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [tspp_pkg::US_W-1:0]      pulse_width_us,
    output logic [tspp_pkg::STEPNUM_W-1:0] step_number,
    output logic [tspp_pkg::PHASE_W-1:0]   phase,
    output logic                           last
);

    localparam int SCB = STEP_COUNT_BITS;
    localparam int CW  = ((SCB > tspp_pkg::TOTAL_W) ? SCB : tspp_pkg::TOTAL_W) + 2;

    // configuration
    logic [31:0]                  max_speed_reg, min_speed_reg, accel_time_reg, step_angle_reg;
    logic [tspp_pkg::TOTAL_W-1:0] total_steps_reg;

    // move state
    logic [SCB-1:0]         steps_done_reg, ramp_steps_reg;
    logic [31:0]            phase_time_reg, step_period_reg, current_speed_reg;
    logic [31:0]            peak_speed_reg, ramp_rate_reg;
    tspp_pkg::phase_t       move_phase_reg, used_phase_reg;
    logic                   moving_reg;
    tspp_pkg::div_sel_t     div_sel_reg;
    logic [63:0]            prod_reg;

    // result register
    logic                           out_valid_reg;
    logic [tspp_pkg::US_W-1:0]      us_reg;
    logic [tspp_pkg::STEPNUM_W-1:0] stepnum_reg;
    logic [tspp_pkg::PHASE_W-1:0]   phase_reg;
    logic                           last_reg;

    logic [31:0] div_num, div_den, div_quo;
    logic        div_busy, div_done;
    logic [31:0] mul_a, mul_b;
    logic        at_end, cruise_over, rate_pos, ramping, out_full;
    logic [32:0] time_sum;
    logic [31:0] time_next;
    logic [63:0] scaled, peak64, dec_diff;
    logic [64:0] acc_sum;
    logic [31:0] acc_speed, dec_speed;
    logic [15:0] us_val;

    // comparisons on counts
    assign at_end      = (CW'(steps_done_reg) + CW'(1)) >= CW'(total_steps_reg);
    assign cruise_over = (CW'(steps_done_reg) + CW'(ramp_steps_reg)) > CW'(total_steps_reg);
    assign rate_pos    = max_speed_reg > min_speed_reg;
    assign ramping     = (move_phase_reg == tspp_pkg::PH_ACCEL)
                         || (move_phase_reg == tspp_pkg::PH_DECEL);
    assign out_full    = out_valid_reg && !out_ready;

    // phase time advance, saturating
    assign time_sum  = {1'b0, phase_time_reg} + {1'b0, step_period_reg};
    assign time_next = time_sum[32] ? tspp_pkg::SAT32 : time_sum[31:0];

    // speed from the registered product
    always_comb
    begin
        scaled    = prod_reg >> FRAC_BITS;
        acc_sum   = {1'b0, scaled} + 65'(min_speed_reg);
        acc_speed = (|acc_sum[64:32]) ? tspp_pkg::SAT32 : acc_sum[31:0];
        peak64    = 64'(peak_speed_reg);
        dec_diff  = peak64 - scaled;
        if (scaled >= peak64 || dec_diff < 64'(min_speed_reg))
            dec_speed = min_speed_reg;
        else
            dec_speed = dec_diff[31:0];
        us_val = (scaled > 64'(tspp_pkg::US_MAX)) ? tspp_pkg::US_MAX : scaled[15:0];
    end

    // divider operands
    always_comb
    begin
        case (cmd.div_sel)
            tspp_pkg::DIV_RATE:
            begin
                div_num = max_speed_reg - min_speed_reg;
                div_den = accel_time_reg;
            end
            tspp_pkg::DIV_PMIN:
            begin
                div_num = step_angle_reg;
                div_den = min_speed_reg;
            end
            default:
            begin
                div_num = step_angle_reg;
                div_den = current_speed_reg;
            end
        endcase
    end

    tspp_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    // multiplier operands
    always_comb
    begin
        case (cmd.mul_sel)
            tspp_pkg::MUL_RAMP:
            begin
                mul_a = ramp_rate_reg;
                mul_b = phase_time_reg;
            end
            default:
            begin
                mul_a = step_period_reg;
                mul_b = tspp_pkg::US_PER_MS;
            end
        endcase
    end

    // registered product
    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
            prod_reg <= {32'd0, mul_a} * {32'd0, mul_b};
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg   <= tspp_pkg::MAX_SPEED_RST;
            min_speed_reg   <= tspp_pkg::MIN_SPEED_RST;
            accel_time_reg  <= tspp_pkg::ACCEL_TIME_RST;
            step_angle_reg  <= tspp_pkg::STEP_ANGLE_RST;
            total_steps_reg <= tspp_pkg::TOTAL_STEPS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tspp_pkg::CFG_MAX_SPEED:   max_speed_reg   <= cfg_data;
                tspp_pkg::CFG_MIN_SPEED:   min_speed_reg   <= cfg_data;
                tspp_pkg::CFG_ACCEL_TIME:  accel_time_reg  <= cfg_data;
                tspp_pkg::CFG_STEP_ANGLE:  step_angle_reg  <= cfg_data;
                tspp_pkg::CFG_TOTAL_STEPS: total_steps_reg <= cfg_data[tspp_pkg::TOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    // move state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_done_reg    <= '0;
            ramp_steps_reg    <= '0;
            phase_time_reg    <= '0;
            step_period_reg   <= '0;
            current_speed_reg <= '0;
            peak_speed_reg    <= '0;
            ramp_rate_reg     <= '0;
            move_phase_reg    <= tspp_pkg::PH_ACCEL;
            used_phase_reg    <= tspp_pkg::PH_ACCEL;
            moving_reg        <= 1'b0;
            div_sel_reg       <= tspp_pkg::DIV_RATE;
        end
        else
        begin
            if (cmd.div_start)
                div_sel_reg <= cmd.div_sel;

            // divider result lands in its target
            if (div_done)
            begin
                if (div_sel_reg == tspp_pkg::DIV_RATE)
                    ramp_rate_reg <= div_quo;
                else
                    step_period_reg <= div_quo;
            end

            if (cmd.begin_load)
            begin
                peak_speed_reg    <= max_speed_reg;
                ramp_rate_reg     <= '0;
                current_speed_reg <= min_speed_reg;
                steps_done_reg    <= '0;
                ramp_steps_reg    <= '0;
                phase_time_reg    <= '0;
                move_phase_reg    <= tspp_pkg::PH_ACCEL;
                moving_reg        <= 1'b1;
            end

            if (cmd.step_adv)
            begin
                steps_done_reg <= steps_done_reg + SCB'(1);
                phase_time_reg <= time_next;
                used_phase_reg <= move_phase_reg;
            end

            // ramp phases: new speed from the product
            if (cmd.speed_upd)
            begin
                if (move_phase_reg == tspp_pkg::PH_ACCEL)
                begin
                    current_speed_reg <= acc_speed;
                    ramp_steps_reg    <= steps_done_reg;
                    if (phase_time_reg > accel_time_reg)
                        move_phase_reg <= tspp_pkg::PH_CRUISE;
                end
                else
                begin
                    current_speed_reg <= dec_speed;
                end
            end

            // cruise: enter deceleration when the remaining steps fall below the ramp step count
            if (cmd.cruise_upd && cruise_over)
            begin
                move_phase_reg <= tspp_pkg::PH_DECEL;
                phase_time_reg <= '0;
                peak_speed_reg <= current_speed_reg;
            end

            if (cmd.stop || (cmd.out_load && at_end))
                moving_reg <= 1'b0;
        end
    end

    // result register, holds until the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            us_reg      <= us_val;
            stepnum_reg <= tspp_pkg::STEPNUM_W'(steps_done_reg);
            phase_reg   <= used_phase_reg;
            last_reg    <= at_end;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pulse_width_us = us_reg;
    assign step_number    = stepnum_reg;
    assign phase          = phase_reg;
    assign last           = last_reg;

    assign status.moving   = moving_reg;
    assign status.at_end   = at_end;
    assign status.rate_pos = rate_pos;
    assign status.ramping  = ramping;
    assign status.div_done = div_done;
    assign status.out_full = out_full;

    // checks
    `TSPP_NEVER(a_div_restart, cmd.div_start && div_busy, "divider started while busy")
    `TSPP_NEVER(a_out_overrun, cmd.out_load && out_full, "result loaded over a waiting beat")
    `TSPP_ASSERT(a_last_stops, cmd.out_load && at_end |=> !moving_reg, "move still runs after last")

endmodule

/* rtl/tspp_ctrl.sv */
// controller state machine: sequences begin, step, multiply, divide and result load
// depends on tspp_pkg
`timescale 1ns / 1ps

module tspp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 begin_req,
    input  tspp_pkg::dp_status_t status,
    output tspp_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_BEGIN = 11'b000_0000_0010,
        S_RATE  = 11'b000_0000_0100,
        S_PMIN  = 11'b000_0000_1000,
        S_CHECK = 11'b000_0001_0000,
        S_PREP  = 11'b000_0010_0000,
        S_UPD   = 11'b000_0100_0000,
        S_DIVST = 11'b000_1000_0000,
        S_PCUR  = 11'b001_0000_0000,
        S_USMUL = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = tspp_pkg::DIV_RATE;
        cmd.mul_sel = tspp_pkg::MUL_RAMP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = begin_req ? S_BEGIN : S_CHECK;
            end
            S_BEGIN:
            begin
                cmd.begin_load = 1'b1;
                cmd.div_start  = 1'b1;
                if (status.rate_pos)
                begin
                    cmd.div_sel = tspp_pkg::DIV_RATE;
                    state_next  = S_RATE;
                end
                else
                begin
                    cmd.div_sel = tspp_pkg::DIV_PMIN;
                    state_next  = S_PMIN;
                end
            end
            S_RATE:
            begin
                if (status.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = tspp_pkg::DIV_PMIN;
                    state_next    = S_PMIN;
                end
            end
            S_PMIN:
            begin
                if (status.div_done)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!status.moving)
                    state_next = S_IDLE;
                else if (status.at_end)
                begin
                    cmd.stop   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.step_adv = 1'b1;
                    state_next   = S_PREP;
                end
            end
            S_PREP:
            begin
                if (status.ramping)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = tspp_pkg::MUL_RAMP;
                    state_next    = S_UPD;
                end
                else
                begin
                    cmd.cruise_upd = 1'b1;
                    state_next     = S_USMUL;
                end
            end
            S_UPD:
            begin
                cmd.speed_upd = 1'b1;
                state_next    = S_DIVST;
            end
            S_DIVST:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = tspp_pkg::DIV_PCUR;
                state_next    = S_PCUR;
            end
            S_PCUR:
            begin
                if (status.div_done)
                    state_next = S_USMUL;
            end
            S_USMUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = tspp_pkg::MUL_US;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (!status.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

/* tb/sv/trapezoid_step_pulse_profile_tb.sv */
// self-checking testbench of the trapezoid step pulse profile block
// drives step requests and register writes, predicts each pulse beat and checks it
// depends on tspp_pkg, the channel interfaces and the block itself
`timescale 1ns / 1ps

module trapezoid_step_pulse_profile_tb;

    localparam int FRAC      = tspp_pkg::FRAC_BITS_DEF;
    localparam int IDLE_WAIT = 300;
    localparam int WD_LIMIT  = 20000;
    localparam int RAND_ITEMS = 1150;

    typedef struct {
        logic [tspp_pkg::US_W-1:0]      us;
        logic [tspp_pkg::STEPNUM_W-1:0] num;
        logic [tspp_pkg::PHASE_W-1:0]   ph;
        logic                           lst;
    } pulse_t;

    logic clk;
    logic rst_n;

    tspp_req_if step_req ();
    tspp_rsp_if step_rsp ();
    tspp_cfg_if cfg ();

    trapezoid_step_pulse_profile u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_req (step_req),
        .step_rsp (step_rsp),
        .cfg      (cfg)
    );

    // register shadow
    logic [31:0]                  r_max, r_min, r_acc, r_ang;
    logic [tspp_pkg::TOTAL_W-1:0] r_total;

    // profile state shadow
    logic [23:0]      p_steps, p_rsteps;
    logic [31:0]      p_time, p_period, p_speed, p_peak, p_rate;
    tspp_pkg::phase_t p_phase;
    bit               p_moving;

    pulse_t pulse_q[$];
    int     errors;
    int     items_sent;
    int     pulses_seen;
    int     cfg_writes;
    int     burst_left;
    int     wd_count;
    int     cyc;

    always #5 clk = ~clk;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        return (v > 64'(tspp_pkg::SAT32)) ? tspp_pkg::SAT32 : v[31:0];
    endfunction

    function automatic logic [31:0] qdiv(input logic [31:0] num, input logic [31:0] den);
        if (den == 32'd0)
            return tspp_pkg::SAT32;
        return sat32(({32'd0, num} << FRAC) / {32'd0, den});
    endfunction

    function automatic logic [63:0] qmul(input logic [31:0] a, input logic [31:0] b);
        return ({32'd0, a} * {32'd0, b}) >> FRAC;
    endfunction

    // advance the profile by one request; returns 1 when a pulse results
    function automatic bit predict_pulse(input logic start, output pulse_t p);
        logic [63:0]      drop;
        logic [63:0]      us;
        tspp_pkg::phase_t used;
        p = '{default: '0};
        if (start)
        begin
            p_peak   = r_max;
            p_rate   = (r_max <= r_min) ? 32'd0 : qdiv(r_max - r_min, r_acc);
            p_period = qdiv(r_ang, r_min);
            p_speed  = r_min;
            p_steps  = '0;
            p_rsteps = '0;
            p_time   = '0;
            p_phase  = tspp_pkg::PH_ACCEL;
            p_moving = 1'b1;
        end
        if (!p_moving)
            return 0;
        if ({1'b0, p_steps} + 25'd1 >= {1'b0, r_total})
        begin
            p_moving = 1'b0;
            return 0;
        end
        p_steps = p_steps + 24'd1;
        p_time  = sat32({32'd0, p_time} + {32'd0, p_period});
        used    = p_phase;
        case (p_phase)
            tspp_pkg::PH_ACCEL:
            begin
                p_speed  = sat32(qmul(p_rate, p_time) + {32'd0, r_min});
                p_period = qdiv(r_ang, p_speed);
                p_rsteps = p_steps;
                if (p_time > r_acc)
                    p_phase = tspp_pkg::PH_CRUISE;
            end
            tspp_pkg::PH_DECEL:
            begin
                drop = qmul(p_rate, p_time);
                if (drop >= {32'd0, p_peak} || ({32'd0, p_peak} - drop) < {32'd0, r_min})
                    p_speed = r_min;
                else
                    p_speed = p_peak - drop[31:0];
                p_period = qdiv(r_ang, p_speed);
            end
            default:
            begin
                if ({1'b0, p_steps} + {1'b0, p_rsteps} > {1'b0, r_total})
                begin
                    p_phase = tspp_pkg::PH_DECEL;
                    p_time  = '0;
                    p_peak  = p_speed;
                end
            end
        endcase
        us    = ({32'd0, p_period} * 64'(tspp_pkg::US_PER_MS)) >> FRAC;
        p.us  = (us > 64'(tspp_pkg::US_MAX)) ? tspp_pkg::US_MAX : us[15:0];
        p.num = p_steps;
        p.ph  = used;
        p.lst = ({1'b0, p_steps} + 25'd1 >= {1'b0, r_total});
        if (p.lst)
            p_moving = 1'b0;
        return 1;
    endfunction

    // send one request beat, sender works in bursts, mostly with gaps between them
    task automatic send_step(input logic start);
        pulse_t p;
        int     gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
            if (gap > 0)
            begin
                step_req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        step_req.valid     <= 1'b1;
        step_req.begin_req <= start;
        @(posedge clk);
        while (!step_req.ready)
            @(posedge clk);
        items_sent++;
        if (predict_pulse(start, p))
            pulse_q.push_back(p);
    endtask

    // drop valid and wait until the block has nothing left to produce
    task automatic wait_idle();
        step_req.valid <= 1'b0;
        burst_left = 0;
        while (pulse_q.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    // one register write beat, with valid dropped again before the task returns
    task automatic write_reg(input tspp_pkg::cfg_idx_t idx, input logic [31:0] d);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= d;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        cfg_writes++;
        case (idx)
            tspp_pkg::CFG_MAX_SPEED:   r_max   = d;
            tspp_pkg::CFG_MIN_SPEED:   r_min   = d;
            tspp_pkg::CFG_ACCEL_TIME:  r_acc   = d;
            tspp_pkg::CFG_STEP_ANGLE:  r_ang   = d;
            tspp_pkg::CFG_TOTAL_STEPS: r_total = d[tspp_pkg::TOTAL_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_all(input logic [31:0] mx, input logic [31:0] mn,
                             input logic [31:0] ac, input logic [31:0] an,
                             input logic [31:0] tot);
        write_reg(tspp_pkg::CFG_MAX_SPEED, mx);
        write_reg(tspp_pkg::CFG_MIN_SPEED, mn);
        write_reg(tspp_pkg::CFG_ACCEL_TIME, ac);
        write_reg(tspp_pkg::CFG_STEP_ANGLE, an);
        write_reg(tspp_pkg::CFG_TOTAL_STEPS, tot);
    endtask

    // requests with no move running give nothing
    task automatic test_idle_requests();
        repeat (3) send_step(1'b0);
        wait_idle();
    endtask

    // extremes of every register and the named corner cases
    task automatic test_directed();
        // shortest move: one pulse marked last, then requests past the end
        write_all(32'd235930, 32'd65536, 32'd6553600, 32'd117965, 32'd2);
        send_step(1'b1);
        send_step(1'b0);
        send_step(1'b0);
        wait_idle();
        // widest speed range, tiny ramp time, huge angle: saturations
        write_all(tspp_pkg::SAT32, 32'd1, 32'd1, tspp_pkg::SAT32, 32'd6);
        send_step(1'b1);
        repeat (5) send_step(1'b0);
        wait_idle();
        // maximum not above minimum gives no ramp
        write_all(32'd1000, tspp_pkg::SAT32, tspp_pkg::SAT32, 32'd1, 32'd5);
        send_step(1'b1);
        repeat (3) send_step(1'b0);
        wait_idle();
        // short ramp into cruise, restart in the middle of a move
        write_all(32'd400000, 32'd65536, 32'd2, 32'd117965, 32'd8);
        send_step(1'b1);
        repeat (3) send_step(1'b0);
        send_step(1'b1);
        repeat (3) send_step(1'b0);
        wait_idle();
        // largest planned count, a few steps only
        write_reg(tspp_pkg::CFG_TOTAL_STEPS, 32'h00FF_FFFF);
        send_step(1'b1);
        send_step(1'b0);
        wait_idle();
    endtask

    function automatic logic [31:0] pick_value(input logic [31:0] lo, input logic [31:0] hi);
        case ($urandom_range(0, 9))
            0:       return tspp_pkg::SAT32;
            1:       return 32'd1;
            2, 3:    return $urandom() | 32'd1;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // random settings, mostly well-formed moves with some noise and restarts
    task automatic test_random_moves();
        int n;
        while (items_sent < RAND_ITEMS)
        begin
            wait_idle();
            write_reg(tspp_pkg::CFG_MAX_SPEED, pick_value(32'd65536, 32'd2000000));
            write_reg(tspp_pkg::CFG_MIN_SPEED, pick_value(32'd1000, 32'd200000));
            write_reg(tspp_pkg::CFG_ACCEL_TIME, pick_value(32'd1, 32'd2000000));
            write_reg(tspp_pkg::CFG_STEP_ANGLE, pick_value(32'd1000, 32'd500000));
            case ($urandom_range(0, 19))
                0:       write_reg(tspp_pkg::CFG_TOTAL_STEPS, 32'h00FF_FFFF);
                1:       write_reg(tspp_pkg::CFG_TOTAL_STEPS, 32'd2);
                2:       write_reg(tspp_pkg::CFG_TOTAL_STEPS, $urandom_range(200, 2));
                default: write_reg(tspp_pkg::CFG_TOTAL_STEPS, $urandom_range(30, 2));
            endcase
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) send_step(1'b0);
            n = (r_total > 60) ? $urandom_range(40, 10) : int'(r_total) + $urandom_range(3, 0);
            send_step(1'b1);
            repeat (n)
                send_step(($urandom_range(0, 29) == 0) ? 1'b1 : 1'b0);
        end
        wait_idle();
    endtask

    // receiver stalls in phases: never, randomly, or heavily
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        case ((cyc / 700) % 3)
            0:       step_rsp.ready <= 1'b1;
            1:       step_rsp.ready <= ($urandom_range(0, 2) != 0);
            default: step_rsp.ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // compare each pulse beat with the oldest prediction
    always @(posedge clk)
    begin
        pulse_t e;
        if (rst_n && step_rsp.valid && step_rsp.ready)
        begin
            pulses_seen++;
            if (pulse_q.size() == 0)
            begin
                $error("pulse beat with nothing expected");
                errors++;
            end
            else
            begin
                e = pulse_q.pop_front();
                if (step_rsp.pulse_width_us !== e.us)
                begin
                    $error("pulse_width_us expected %0d got %0d", e.us, step_rsp.pulse_width_us);
                    errors++;
                end
                if (step_rsp.step_number !== e.num)
                begin
                    $error("step_number expected %0d got %0d", e.num, step_rsp.step_number);
                    errors++;
                end
                if (step_rsp.phase !== e.ph)
                begin
                    $error("phase expected %0d got %0d", e.ph, step_rsp.phase);
                    errors++;
                end
                if (step_rsp.last !== e.lst)
                begin
                    $error("last expected %0d got %0d", e.lst, step_rsp.last);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((step_req.valid && step_req.ready) || (step_rsp.valid && step_rsp.ready)
            || (cfg.valid && cfg.ready))
            wd_count <= 0;
        else
            wd_count <= wd_count + 1;
        if (wd_count >= WD_LIMIT)
        begin
            $display("trapezoid_step_pulse_profile verification failed");
            $finish;
        end
    end

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        step_req.valid     = 1'b0;
        step_req.begin_req = 1'b0;
        step_rsp.ready     = 1'b0;
        cfg.valid          = 1'b0;
        cfg.index          = tspp_pkg::CFG_MAX_SPEED;
        cfg.data           = '0;
        cyc                = 0;
        wd_count           = 0;
        errors             = 0;
        items_sent         = 0;
        pulses_seen        = 0;
        cfg_writes         = 0;
        burst_left         = 0;
        r_max    = tspp_pkg::MAX_SPEED_RST;
        r_min    = tspp_pkg::MIN_SPEED_RST;
        r_acc    = tspp_pkg::ACCEL_TIME_RST;
        r_ang    = tspp_pkg::STEP_ANGLE_RST;
        r_total  = tspp_pkg::TOTAL_STEPS_RST;
        p_steps  = '0;
        p_rsteps = '0;
        p_time   = '0;
        p_period = '0;
        p_speed  = '0;
        p_peak   = '0;
        p_rate   = '0;
        p_phase  = tspp_pkg::PH_ACCEL;
        p_moving = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_requests();
        test_directed();
        test_random_moves();

        $display("covered %0d step requests, %0d pulse beats, %0d register writes",
                 items_sent, pulses_seen, cfg_writes);
        if (errors == 0 && pulse_q.size() == 0)
            $display("trapezoid_step_pulse_profile verification clean");
        else
            $display("trapezoid_step_pulse_profile verification failed");
        $finish;
    end

endmodule
